// ----- rtl/pmst_pkg.sv -----
// Shared types and constants of the dense Prim minimum spanning tree engine.
package pmst_pkg;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_COST_BITS    = 8;

    localparam int VERTEX_W = 4;
    localparam int WEIGHT_W = 8;
    localparam int COUNT_W  = 5;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_PASS,
        ST_FLUSH,
        ST_DECIDE,
        ST_EMIT_PREV,
        ST_COMMIT,
        ST_EMIT_LAST,
        ST_EMIT_EMPTY,
        ST_EMIT_BAD
    } ctl_state_t;

    typedef enum logic [1:0] {
        EK_EDGE,
        EK_EDGE_LAST,
        EK_EMPTY,
        EK_BAD
    } emit_kind_t;

    typedef struct packed {
        logic       clear_step;
        logic       idle;
        logic       init;
        logic       pass_issue;
        logic       commit;
        logic       emit;
        emit_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic start_req;
        logic start_bad;
        logic single;
        logic pass_last;
        logic found;
        logic pending;
        logic commit_full;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/pmst_ctrl.sv -----
// Sequencing state machine of the spanning tree engine.
module pmst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  pmst_pkg::status_t   sts,
    output pmst_pkg::cmd_t      cmd,
    output pmst_pkg::ctl_state_t state
);
    import pmst_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sts.start_req)
                begin
                    state_next = sts.start_bad ? ST_EMIT_BAD : ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = sts.single ? ST_EMIT_EMPTY : ST_PASS;
            end
            ST_PASS:
            begin
                if (sts.pass_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (sts.found)
                begin
                    state_next = sts.pending ? ST_EMIT_PREV : ST_COMMIT;
                end
                else
                begin
                    state_next = sts.pending ? ST_EMIT_LAST : ST_EMIT_EMPTY;
                end
            end
            ST_EMIT_PREV:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = sts.commit_full ? ST_EMIT_LAST : ST_PASS;
            end
            ST_EMIT_LAST, ST_EMIT_EMPTY, ST_EMIT_BAD:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.kind = EK_EDGE;
        unique case (state_reg)
            ST_CLEAR:      cmd.clear_step = 1'b1;
            ST_IDLE:       cmd.idle = 1'b1;
            ST_INIT:       cmd.init = 1'b1;
            ST_PASS:       cmd.pass_issue = 1'b1;
            ST_COMMIT:     cmd.commit = 1'b1;
            ST_EMIT_PREV:
            begin
                cmd.emit = sts.out_free;
                cmd.kind = EK_EDGE;
            end
            ST_EMIT_LAST:
            begin
                cmd.emit = sts.out_free;
                cmd.kind = EK_EDGE_LAST;
            end
            ST_EMIT_EMPTY:
            begin
                cmd.emit = sts.out_free;
                cmd.kind = EK_EMPTY;
            end
            ST_EMIT_BAD:
            begin
                cmd.emit = sts.out_free;
                cmd.kind = EK_BAD;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

// ----- rtl/pmst_datapath.sv -----
// Adjacency memory, key arrays, pass scanner and result register of the engine.
module pmst_datapath #(
    parameter int MAX_VERTICES = pmst_pkg::DEF_MAX_VERTICES,
    parameter int COST_BITS    = pmst_pkg::DEF_COST_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pmst_pkg::cmd_t                    cmd,
    output pmst_pkg::status_t                 sts,
    input  logic                              cfg_write,
    input  logic [pmst_pkg::COUNT_W-1:0]      cfg_data,
    input  logic                              in_valid,
    input  logic                              mode,
    input  logic [pmst_pkg::VERTEX_W-1:0]     row_vertex,
    input  logic [pmst_pkg::VERTEX_W-1:0]     col_vertex,
    input  logic                              edge_present,
    input  logic [pmst_pkg::WEIGHT_W-1:0]     edge_weight,
    input  logic [pmst_pkg::VERTEX_W-1:0]     start_vertex,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pmst_pkg::VERTEX_W-1:0]     parent_vertex,
    output logic [pmst_pkg::VERTEX_W-1:0]     child_vertex,
    output logic [pmst_pkg::WEIGHT_W-1:0]     tree_edge_cost,
    output logic                              edge_valid,
    output logic                              all_reached,
    output logic                              last
);
    import pmst_pkg::*;

    localparam int VW        = $clog2(MAX_VERTICES);
    localparam int NW        = $clog2(MAX_VERTICES + 1);
    localparam int KW        = COST_BITS + 1;
    localparam int AW        = 2 * VW;
    localparam int ADJ_DEPTH = 1 << AW;
    localparam int MW        = COST_BITS + 1;
    localparam int EW        = VW + VERTEX_W;
    localparam logic [KW-1:0] KEY_INF = {1'b1, {COST_BITS{1'b0}}};

    // Adjacency memory: one word per unordered pair, indexed by {low, high}.
    logic [MW-1:0] adj_mem [ADJ_DEPTH];
    logic [MW-1:0] rd_word_reg;

    logic             in_tree_reg [MAX_VERTICES];
    logic [KW-1:0]    key_reg     [MAX_VERTICES];
    logic [VW-1:0]    parent_reg  [MAX_VERTICES];

    logic [COUNT_W-1:0] vc_reg, vc_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [VW-1:0]      s_reg, s_next;
    logic [VW-1:0]      from_reg, from_next;
    logic [VW-1:0]      cnt_reg, cnt_next;
    logic               proc_valid_reg, proc_valid_next;
    logic [VW-1:0]      vq_reg, vq_next;
    logic [KW-1:0]      min_reg, min_next;
    logic [VW-1:0]      best_reg, best_next;
    logic [NW-1:0]      joined_reg, joined_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [VW-1:0]      pend_parent_reg;
    logic [VW-1:0]      pend_child_reg;
    logic [COST_BITS-1:0] pend_cost_reg;
    logic               out_valid_reg, out_valid_next;
    logic [VERTEX_W-1:0] out_parent_reg, out_child_reg;
    logic [WEIGHT_W-1:0] out_cost_reg;
    logic               out_edge_reg, out_all_reg, out_last_reg;

    logic [EW-1:0]        row_ext, col_ext, start_ext;
    logic [VW-1:0]        row_idx, col_idx;
    logic                 load_ok, load_wr;
    logic [COST_BITS+WEIGHT_W-1:0] w_ext;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [MW-1:0]        wr_data;
    logic                 wr_en;
    logic [NW-1:0]        n_clamp;
    logic                 start_acc;
    logic [VW-1:0]        lo_v, hi_v;
    logic                 tin_q, upd_q, cand_q;
    logic [KW-1:0]        kcur_q, nk_q;
    logic                 out_free;
    logic [EW-1:0]        pv_ext, cv_ext;
    logic [COST_BITS+WEIGHT_W-1:0] cost_ext;

    // Load decode.
    assign row_ext   = {{VW{1'b0}}, row_vertex};
    assign col_ext   = {{VW{1'b0}}, col_vertex};
    assign start_ext = {{VW{1'b0}}, start_vertex};
    assign row_idx   = row_ext[VW-1:0];
    assign col_idx   = col_ext[VW-1:0];
    assign load_ok   = (row_ext != col_ext) && (row_ext < EW'(MAX_VERTICES))
                       && (col_ext < EW'(MAX_VERTICES));
    assign load_wr   = cmd.idle && in_valid && !mode && load_ok;
    assign w_ext     = {{COST_BITS{1'b0}}, edge_weight};
    assign start_acc = cmd.idle && in_valid && mode;

    assign n_clamp = (32'(vc_reg) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = '0;
        if (cmd.clear_step)
        begin
            wr_en = 1'b1;
        end
        else if (load_wr)
        begin
            wr_en = 1'b1;
            if (row_idx < col_idx)
            begin
                wr_addr = {row_idx, col_idx};
            end
            else
            begin
                wr_addr = {col_idx, row_idx};
            end
            wr_data = {edge_present, w_ext[COST_BITS-1:0]};
        end
    end

    assign lo_v    = (from_reg < cnt_reg) ? from_reg : cnt_reg;
    assign hi_v    = (from_reg < cnt_reg) ? cnt_reg : from_reg;
    assign rd_addr = {lo_v, hi_v};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            adj_mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= adj_mem[rd_addr];
    end

    // Relaxation of the vertex read last cycle, folded with the running minimum.
    assign tin_q  = in_tree_reg[vq_reg];
    assign kcur_q = key_reg[vq_reg];
    assign upd_q  = proc_valid_reg && !tin_q && rd_word_reg[MW-1]
                    && ({1'b0, rd_word_reg[COST_BITS-1:0]} < kcur_q);
    assign nk_q   = upd_q ? {1'b0, rd_word_reg[COST_BITS-1:0]} : kcur_q;
    assign cand_q = proc_valid_reg && !tin_q && (nk_q < min_reg);

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        vc_next         = cfg_write ? cfg_data : vc_reg;
        clr_cnt_next    = cmd.clear_step ? clr_cnt_reg + AW'(1) : clr_cnt_reg;
        n_next          = start_acc ? n_clamp : n_reg;
        s_next          = start_acc ? start_ext[VW-1:0] : s_reg;
        from_next       = from_reg;
        cnt_next        = cmd.pass_issue ? cnt_reg + VW'(1) : cnt_reg;
        proc_valid_next = cmd.pass_issue;
        vq_next         = cnt_reg;
        min_next        = cand_q ? nk_q : min_reg;
        best_next       = cand_q ? vq_reg : best_reg;
        joined_next     = joined_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        if (cmd.init)
        begin
            from_next       = s_reg;
            cnt_next        = '0;
            min_next        = KEY_INF;
            joined_next     = NW'(1);
            pend_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            from_next       = best_reg;
            cnt_next        = '0;
            min_next        = KEY_INF;
            joined_next     = joined_reg + NW'(1);
            pend_valid_next = 1'b1;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg         <= VERTEX_COUNT_RESET;
            clr_cnt_reg    <= '0;
            n_reg          <= '0;
            s_reg          <= '0;
            from_reg       <= '0;
            cnt_reg        <= '0;
            proc_valid_reg <= 1'b0;
            vq_reg         <= '0;
            min_reg        <= KEY_INF;
            best_reg       <= '0;
            joined_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            vc_reg         <= vc_next;
            clr_cnt_reg    <= clr_cnt_next;
            n_reg          <= n_next;
            s_reg          <= s_next;
            from_reg       <= from_next;
            cnt_reg        <= cnt_next;
            proc_valid_reg <= proc_valid_next;
            vq_reg         <= vq_next;
            min_reg        <= min_next;
            best_reg       <= best_next;
            joined_reg     <= joined_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Tree membership: on a start only the start vertex is marked; keys go to infinity and parents to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                in_tree_reg[i] <= 1'b0;
            end
        end
        else if (cmd.init)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                in_tree_reg[i] <= (VW'(i) == s_reg);
            end
        end
        else if (cmd.commit)
        begin
            in_tree_reg[best_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                key_reg[i]    <= KEY_INF;
                parent_reg[i] <= '0;
            end
        end
        else if (upd_q)
        begin
            key_reg[vq_reg]    <= nk_q;
            parent_reg[vq_reg] <= from_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            pend_parent_reg <= parent_reg[best_reg];
            pend_child_reg  <= best_reg;
            pend_cost_reg   <= min_reg[COST_BITS-1:0];
        end
    end

    assign pv_ext   = {{VERTEX_W{1'b0}}, pend_parent_reg};
    assign cv_ext   = {{VERTEX_W{1'b0}}, pend_child_reg};
    assign cost_ext = {{WEIGHT_W{1'b0}}, pend_cost_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.kind)
                EK_EDGE, EK_EDGE_LAST:
                begin
                    out_parent_reg <= pv_ext[VERTEX_W-1:0];
                    out_child_reg  <= cv_ext[VERTEX_W-1:0];
                    out_cost_reg   <= cost_ext[WEIGHT_W-1:0];
                    out_edge_reg   <= 1'b1;
                end
                default:
                begin
                    out_parent_reg <= '0;
                    out_child_reg  <= '0;
                    out_cost_reg   <= '0;
                    out_edge_reg   <= 1'b0;
                end
            endcase
            out_last_reg <= (cmd.kind != EK_EDGE);
            out_all_reg  <= ((cmd.kind == EK_EDGE_LAST) || (cmd.kind == EK_EMPTY))
                            && (joined_reg == n_reg);
        end
    end

    assign sts.clear_done  = &clr_cnt_reg;
    assign sts.start_req   = in_valid && mode;
    assign sts.start_bad   = (32'(start_vertex) >= 32'(n_clamp));
    assign sts.single      = (n_reg == NW'(1));
    assign sts.pass_last   = (NW'(cnt_reg) == n_reg - NW'(1));
    assign sts.found       = (min_reg != KEY_INF);
    assign sts.pending     = pend_valid_reg;
    assign sts.commit_full = (joined_reg + NW'(1) == n_reg);
    assign sts.out_free    = out_free;

    assign out_valid      = out_valid_reg;
    assign parent_vertex  = out_parent_reg;
    assign child_vertex   = out_child_reg;
    assign tree_edge_cost = out_cost_reg;
    assign edge_valid     = out_edge_reg;
    assign all_reached    = out_all_reg;
    assign last           = out_last_reg;

endmodule

// ----- rtl/prim_minimum_spanning_tree_top.sv -----
// Top level of the dense Prim minimum spanning tree engine.
//
//  Channel   Direction  Handshake              Contents
//  in        request in in_valid / in_stall    load of one edge, or start of a tree
//  out       result out out_valid / out_stall  one tree edge, or one empty result
//  cfg       write only cfg_write / cfg_data   vertex count in use
//
// A load request for two distinct vertices below MAX_VERTICES writes one word of
// the adjacency memory, which keeps each undirected edge once, under the pair
// {lower, higher vertex}. A start request runs one scan pass per vertex that
// joins the tree. A pass reads one adjacency word per cycle through the single
// memory read port into the read and relax pipeline. After reset a clearing
// pass writes every adjacency word once, 2^(2*ceil(log2 MAX_VERTICES)) words
// (256 by default), during which in_stall is high. in_stall is high whenever a
// start request is in progress; a full result register holds its result until
// out_stall falls, and the engine waits for it.
module prim_minimum_spanning_tree_top #(
    parameter int MAX_VERTICES = pmst_pkg::DEF_MAX_VERTICES,
    parameter int COST_BITS    = pmst_pkg::DEF_COST_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pmst_pkg::COUNT_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [pmst_pkg::VERTEX_W-1:0]     row_vertex,
    input  logic [pmst_pkg::VERTEX_W-1:0]     col_vertex,
    input  logic                              edge_present,
    input  logic [pmst_pkg::WEIGHT_W-1:0]     edge_weight,
    input  logic [pmst_pkg::VERTEX_W-1:0]     start_vertex,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pmst_pkg::VERTEX_W-1:0]     parent_vertex,
    output logic [pmst_pkg::VERTEX_W-1:0]     child_vertex,
    output logic [pmst_pkg::WEIGHT_W-1:0]     tree_edge_cost,
    output logic                              edge_valid,
    output logic                              all_reached,
    output logic                              last
);
    import pmst_pkg::*;

    cmd_t       cmd;
    status_t    sts;
    ctl_state_t state;

    // The controller sequences clearing, loads, scan passes and result emission.
    pmst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd),
        .state (state)
    );

    // The datapath holds the adjacency memory, the per-vertex keys and the result register.
    pmst_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COST_BITS    (COST_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .mode           (mode),
        .row_vertex     (row_vertex),
        .col_vertex     (col_vertex),
        .edge_present   (edge_present),
        .edge_weight    (edge_weight),
        .start_vertex   (start_vertex),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .parent_vertex  (parent_vertex),
        .child_vertex   (child_vertex),
        .tree_edge_cost (tree_edge_cost),
        .edge_valid     (edge_valid),
        .all_reached    (all_reached),
        .last           (last)
    );

    // Requests are taken only while the engine is idle.
    assign in_stall = !cmd.idle;

    // No result can appear while the adjacency memory is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_CLEAR) |-> !out_valid)
        else $error("result presented during clearing pass");

    // A result without an edge is always the final result of its start request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !edge_valid) |-> last)
        else $error("empty result not marked last");

    // A tree edge always joins a new vertex to a different tree vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && edge_valid) |-> (parent_vertex != child_vertex))
        else $error("tree edge with equal endpoints");

    // An accepted start request always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode) |=> (state != ST_IDLE))
        else $error("start request accepted without leaving idle");

endmodule
